// File: design/fwrl_pkg.sv
// fwrl_pkg: field widths, register codes, reset values and the table entry type
// for the fixed window rate limiter; no dependencies
`default_nettype none

package fwrl_pkg;

    // field widths
    localparam int KEY_W   = 64;
    localparam int TIME_W  = 48;
    localparam int CNT_W   = 16;
    localparam int WIN_W   = 27;
    localparam int RETRY_W = 17;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    // parameter defaults
    localparam int unsigned DEF_TABLE_ENTRIES    = 64;
    localparam int unsigned DEF_TICKS_PER_SECOND = 1000;

    // register reset values
    localparam logic [CNT_W-1:0] DEF_MAX_REQUESTS = 16'd100;
    localparam logic [WIN_W-1:0] DEF_WINDOW_MS    = 27'd60000;

    // register index codes (byte address bit 2)
    localparam logic REG_MAX_REQUESTS = 1'b0;
    localparam logic REG_WINDOW_MS    = 1'b1;

    // retry saturation and floor
    localparam logic [RETRY_W-1:0] RETRY_MAX = '1;
    localparam logic [RETRY_W-1:0] RETRY_MIN = 17'd1;

    // saturated time value
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    // one table entry as kept in the slot memory
    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [CNT_W-1:0]  count;
        logic [TIME_W-1:0] window_end;
    } slot_t;

endpackage

`default_nettype wire

// File: design/per_client_fixed_window_rate_limiter.sv
// per_client_fixed_window_rate_limiter: scan-based per-client request limiter
// with slot memory, one compare stage and a reciprocal multiplier for the retry time
// depends on fwrl_pkg
`default_nettype none

// Usage
// A request beat (client_key, now_ms) is taken at a rising edge with start high
// and busy low. Exactly one result beat follows: done is high for one cycle with
// allowed, retry_after_s and table_full, and the receiver cannot stall it.
// Registers max_requests (0x0) and window_ms (0x4) are written over the APB
// port; the user must write them only while the block is idle, which the block
// itself does not enforce. pready is always high, reads return the value.
// Sequence: the slot memory is read one entry per cycle during a scan, each
// entry is judged in the compare stage, then a decide state updates the matched
// or free slot and gives an allowed or untracked result beat. A denied request
// then passes a divide state that turns the time left into seconds by reciprocal multiplication.
// The next request can be taken at the edge that ends the done cycle; no new
// request is taken while one is in progress.
// Reset: after rst_n releases, a clearing pass writes every slot invalid, one
// slot per cycle; busy stays high meanwhile.
// Registers return to max_requests = 100 and window_ms = 60000.
module per_client_fixed_window_rate_limiter
    import fwrl_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES    = DEF_TABLE_ENTRIES,
    parameter int unsigned TICKS_PER_SECOND = DEF_TICKS_PER_SECOND
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // configuration port
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ADDR_W-1:0]   paddr,
    input  wire logic [DATA_W-1:0]   pwdata,
    output logic      [DATA_W-1:0]   prdata,
    output logic                     pready,
    // request channel
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [KEY_W-1:0]    client_key,
    input  wire logic [TIME_W-1:0]   now_ms,
    // result channel
    output logic                     done,
    output logic                     allowed,
    output logic [RETRY_W-1:0]       retry_after_s,
    output logic                     table_full
);

    localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int SCAN_W = IDX_W + 1;
    localparam logic [SCAN_W-1:0] ENTRIES_C = SCAN_W'(TABLE_ENTRIES);
    localparam logic [SCAN_W-1:0] LAST_C    = SCAN_W'(TABLE_ENTRIES - 1);

    // time left at or above SAT_L saturates the retry field, below it the
    // quotient comes from a multiply by a rounded-up reciprocal and a shift
    localparam longint unsigned SAT_L = 64'(TICKS_PER_SECOND) << RETRY_W;
    localparam int QN_W    = $clog2(SAT_L);
    localparam int TPS_LOG = $clog2(TICKS_PER_SECOND);
    localparam int SH_W    = QN_W + TPS_LOG;
    localparam int RCP_W   = QN_W + 1;
    localparam int PROD_W  = QN_W + RCP_W;
    localparam longint unsigned RECIP_L =
        ((64'd1 << SH_W) + 64'(TICKS_PER_SECOND) - 64'd1) / 64'(TICKS_PER_SECOND);
    localparam logic [TIME_W-1:0] SAT_C   = TIME_W'(SAT_L);
    localparam logic [TIME_W-1:0] TPS_C   = TIME_W'(TICKS_PER_SECOND);
    localparam logic [RCP_W-1:0]  RECIP_C = RCP_W'(RECIP_L);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_DIV
    } state_t;

    // control registers
    state_t              state_reg, state_next;
    logic [SCAN_W-1:0]   scan_reg, scan_next;
    logic                chk_vld_reg, chk_vld_next;
    logic                hit_found_reg, hit_found_next;
    logic                free_found_reg, free_found_next;
    logic                done_reg, done_next;
    logic                allowed_reg, allowed_next;
    logic [RETRY_W-1:0]  retry_reg, retry_next;
    logic                full_reg, full_next;
    logic [CNT_W-1:0]    max_req_reg, max_req_next;
    logic [WIN_W-1:0]    window_reg, window_next;

    // payload registers
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [TIME_W-1:0]   new_end_reg, new_end_next;
    logic [IDX_W-1:0]    chk_idx_reg, chk_idx_next;
    logic [IDX_W-1:0]    hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0]    free_idx_reg, free_idx_next;
    logic [CNT_W-1:0]    hit_cnt_reg, hit_cnt_next;
    logic [TIME_W-1:0]   hit_end_reg, hit_end_next;
    logic                hit_exp_reg, hit_exp_next;
    logic [TIME_W-1:0]   dvd_reg, dvd_next;

    // slot memory
    slot_t               slot_mem [TABLE_ENTRIES];
    slot_t               rd_data_reg;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    slot_t               mem_wdata;

    // helpers
    logic                cfg_wr;
    logic                accept;
    logic [TIME_W:0]     end_sum;
    logic                rd_expired;
    logic [IDX_W-1:0]    tgt_idx;
    logic                renew;
    logic [CNT_W-1:0]    cnt0;
    logic [TIME_W-1:0]   end0;
    logic                deny;
    logic [PROD_W-1:0]   quot_prod;
    logic [RETRY_W-1:0]  quot;

    assign cfg_wr = psel && penable && pwrite && pready;
    assign accept = start && !busy;
    assign pready = 1'b1;
    assign busy   = (state_reg != ST_IDLE);

    assign done          = done_reg;
    assign allowed       = allowed_reg;
    assign retry_after_s = retry_reg;
    assign table_full    = full_reg;

    // register readback
    always_comb
    begin
        case (paddr[2])
            REG_MAX_REQUESTS: prdata = DATA_W'(max_req_reg);
            REG_WINDOW_MS:    prdata = DATA_W'(window_reg);
            default:          prdata = '0;
        endcase
    end

    // fresh window end, saturated at the top of the time range
    assign end_sum = {1'b0, now_ms} + (TIME_W + 1)'(window_reg);

    // slot read and expiry compare
    assign rd_en      = (state_reg == ST_SCAN) && (scan_reg < ENTRIES_C);
    assign rd_addr    = scan_reg[IDX_W-1:0];
    assign rd_expired = (rd_data_reg.window_end <= now_reg);

    // decide stage terms
    assign tgt_idx = hit_found_reg ? hit_idx_reg : free_idx_reg;
    assign renew   = !hit_found_reg || hit_exp_reg;
    assign cnt0    = renew ? '0 : hit_cnt_reg;
    assign end0    = renew ? new_end_reg : hit_end_reg;
    assign deny    = (cnt0 >= max_req_reg);

    // whole seconds of time left by reciprocal multiplication
    assign quot_prod = {{RCP_W{1'b0}}, dvd_reg[QN_W-1:0]} * {{QN_W{1'b0}}, RECIP_C};
    assign quot      = quot_prod[SH_W +: RETRY_W];

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        scan_next       = scan_reg;
        chk_vld_next    = rd_en;
        hit_found_next  = hit_found_reg;
        free_found_next = free_found_reg;
        done_next       = 1'b0;
        allowed_next    = allowed_reg;
        retry_next      = retry_reg;
        full_next       = full_reg;
        max_req_next    = max_req_reg;
        window_next     = window_reg;
        key_next        = key_reg;
        now_next        = now_reg;
        new_end_next    = new_end_reg;
        chk_idx_next    = rd_addr;
        hit_idx_next    = hit_idx_reg;
        free_idx_next   = free_idx_reg;
        hit_cnt_next    = hit_cnt_reg;
        hit_end_next    = hit_end_reg;
        hit_exp_next    = hit_exp_reg;
        dvd_next        = dvd_reg;
        mem_we          = 1'b0;
        mem_waddr       = tgt_idx;
        mem_wdata       = '{valid: 1'b1, key: key_reg,
                            count: deny ? cnt0 : cnt0 + 1'b1, window_end: end0};

        // configuration writes
        if (cfg_wr)
        begin
            case (paddr[2])
                REG_MAX_REQUESTS: max_req_next = pwdata[CNT_W-1:0];
                REG_WINDOW_MS:    window_next  = pwdata[WIN_W-1:0];
                default:          ;
            endcase
        end

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = scan_reg[IDX_W-1:0];
                mem_wdata = '0;
                if (scan_reg == LAST_C)
                begin
                    scan_next  = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    key_next        = client_key;
                    now_next        = now_ms;
                    new_end_next    = end_sum[TIME_W] ? TIME_MAX : end_sum[TIME_W-1:0];
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    scan_next       = '0;
                    state_next      = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (rd_en)
                begin
                    scan_next = scan_reg + 1'b1;
                end
                // judge the slot read in the previous cycle
                if (chk_vld_reg)
                begin
                    if (rd_data_reg.valid)
                    begin
                        if (!hit_found_reg && (rd_data_reg.key == key_reg))
                        begin
                            hit_found_next = 1'b1;
                            hit_idx_next   = chk_idx_reg;
                            hit_cnt_next   = rd_data_reg.count;
                            hit_end_next   = rd_data_reg.window_end;
                            hit_exp_next   = rd_expired;
                        end
                        else if (!free_found_reg && rd_expired)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = chk_idx_reg;
                        end
                    end
                    else if (!free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = chk_idx_reg;
                    end
                end
                if (!rd_en && chk_vld_reg)
                begin
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                if (!hit_found_reg && !free_found_reg)
                begin
                    // no room: pass untracked
                    done_next    = 1'b1;
                    allowed_next = 1'b1;
                    retry_next   = '0;
                    full_next    = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    mem_we = 1'b1;
                    if (deny)
                    begin
                        dvd_next   = end0 - now_reg;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        done_next    = 1'b1;
                        allowed_next = 1'b1;
                        retry_next   = '0;
                        full_next    = 1'b0;
                        state_next   = ST_IDLE;
                    end
                end
            end

            ST_DIV:
            begin
                // quotient floored at one second and capped at the field maximum
                done_next    = 1'b1;
                allowed_next = 1'b0;
                full_next    = 1'b0;
                if (dvd_reg >= SAT_C)
                begin
                    retry_next = RETRY_MAX;
                end
                else if (dvd_reg < TPS_C)
                begin
                    retry_next = RETRY_MIN;
                end
                else
                begin
                    retry_next = quot;
                end
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            scan_reg       <= '0;
            chk_vld_reg    <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            done_reg       <= 1'b0;
            allowed_reg    <= 1'b0;
            retry_reg      <= '0;
            full_reg       <= 1'b0;
            max_req_reg    <= DEF_MAX_REQUESTS;
            window_reg     <= DEF_WINDOW_MS;
        end
        else
        begin
            state_reg      <= state_next;
            scan_reg       <= scan_next;
            chk_vld_reg    <= chk_vld_next;
            hit_found_reg  <= hit_found_next;
            free_found_reg <= free_found_next;
            done_reg       <= done_next;
            allowed_reg    <= allowed_next;
            retry_reg      <= retry_next;
            full_reg       <= full_next;
            max_req_reg    <= max_req_next;
            window_reg     <= window_next;
        end
    end

    // request payload and scan results
    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        now_reg      <= now_next;
        new_end_reg  <= new_end_next;
        chk_idx_reg  <= chk_idx_next;
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
        hit_cnt_reg  <= hit_cnt_next;
        hit_end_reg  <= hit_end_next;
        hit_exp_reg  <= hit_exp_next;
        dvd_reg      <= dvd_next;
    end

    // slot memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

`ifndef SYNTHESIS
    // a result beat only follows a decide or retry cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == ST_DECIDE) || ($past(state_reg) == ST_DIV))
        else $error("result beat without a finished request");

    // a denied request always carries a nonzero retry time
    assert property (@(posedge clk) disable iff (!rst_n)
        done && !allowed |-> (retry_after_s != '0) && !table_full)
        else $error("denied beat with zero retry or table full flag");

    // an untracked request passes with no retry time
    assert property (@(posedge clk) disable iff (!rst_n)
        done && table_full |-> allowed && (retry_after_s == '0))
        else $error("table full beat not a plain pass");

    // an accepted request makes the block busy until its result
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy && !done)
        else $error("accepted request did not hold the block busy");
`endif

endmodule

`default_nettype wire

// File: verif/per_client_fixed_window_rate_limiter_tb.sv
// per_client_fixed_window_rate_limiter_tb: self-checking bench for the per-client limiter,
// with an in-bench model of the slot table, APB register writes and read-back
// depends on fwrl_pkg and per_client_fixed_window_rate_limiter
module per_client_fixed_window_rate_limiter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fwrl_pkg::*;

    localparam int SLOTS       = DEF_TABLE_ENTRIES;
    localparam int PHASES      = 10;
    localparam int PHASE_BEATS = 105;
    localparam int SETTLE      = 8;
    localparam int TAIL        = 130;
    localparam int CYCLE_LIMIT = 800000;
    localparam logic [WIN_W-1:0] WINDOW_TOP = '1;

    // one decision as seen on the result ports
    typedef struct packed {
        logic               allowed;
        logic [RETRY_W-1:0] retry;
        logic               full;
    } verdict_t;

    // tracks the client table and the decisions still owed by the block
    class rate_ledger;
        logic [CNT_W-1:0]  limit;
        logic [WIN_W-1:0]  window;
        bit                live   [SLOTS];
        logic [KEY_W-1:0]  owner  [SLOTS];
        logic [CNT_W-1:0]  tally  [SLOTS];
        logic [TIME_W-1:0] closes [SLOTS];
        verdict_t          owed_verdicts[$];
        int                mismatches;
        int                n_allowed;
        int                n_denied;
        int                n_untracked;

        function new();
            limit  = DEF_MAX_REQUESTS;
            window = DEF_WINDOW_MS;
            foreach (live[i])
                live[i] = 1'b0;
            mismatches  = 0;
            n_allowed   = 0;
            n_denied    = 0;
            n_untracked = 0;
        endfunction

        // window end from now, saturated at the top of the time range
        function logic [TIME_W-1:0] window_close(input logic [TIME_W-1:0] now);
            logic [TIME_W:0] sum;
            sum = {1'b0, now} + {{(TIME_W + 1 - WIN_W){1'b0}}, window};
            return sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
        endfunction

        // decide one accepted request beat and queue the decision
        function void note_request(input logic [KEY_W-1:0] key, input logic [TIME_W-1:0] now);
            int                hit;
            int                vacant;
            verdict_t          v;
            logic [TIME_W-1:0] secs;
            hit    = -1;
            vacant = -1;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (live[i])
                begin
                    if (hit < 0 && owner[i] == key)
                        hit = i;
                    else if (vacant < 0 && closes[i] <= now)
                        vacant = i;
                end
                else if (vacant < 0)
                    vacant = i;
            end
            v.allowed = 1'b1;
            v.retry   = '0;
            v.full    = 1'b0;
            if (hit < 0 && vacant < 0)
            begin
                // no slot left: passes untracked
                v.full = 1'b1;
                n_untracked++;
            end
            else
            begin
                if (hit < 0)
                begin
                    hit         = vacant;
                    live[hit]   = 1'b1;
                    owner[hit]  = key;
                    tally[hit]  = '0;
                    closes[hit] = window_close(now);
                end
                else if (closes[hit] <= now)
                begin
                    tally[hit]  = '0;
                    closes[hit] = window_close(now);
                end
                if (tally[hit] >= limit)
                begin
                    // whole seconds to the window end, floor 1, capped at field max
                    secs = (closes[hit] - now) / DEF_TICKS_PER_SECOND;
                    if (secs == 0)
                        secs = 1;
                    if (secs > RETRY_MAX)
                        secs = RETRY_MAX;
                    v.allowed = 1'b0;
                    v.retry   = secs[RETRY_W-1:0];
                    n_denied++;
                end
                else
                begin
                    tally[hit] = tally[hit] + 1'b1;
                    n_allowed++;
                end
            end
            owed_verdicts.push_back(v);
        endfunction

        // compare one result beat with the oldest owed decision
        function void check_verdict(input logic a, input logic [RETRY_W-1:0] r, input logic f);
            verdict_t want;
            if (owed_verdicts.size() == 0)
            begin
                $display("%0t: result beat with nothing owed (allowed %b retry %0d full %b)",
                         $time, a, r, f);
                mismatches++;
                return;
            end
            want = owed_verdicts.pop_front();
            if (a !== want.allowed)
            begin
                $display("%0t: allowed expected %b actual %b", $time, want.allowed, a);
                mismatches++;
            end
            if (r !== want.retry)
            begin
                $display("%0t: retry_after_s expected %0d actual %0d", $time, want.retry, r);
                mismatches++;
            end
            if (f !== want.full)
            begin
                $display("%0t: table_full expected %b actual %b", $time, want.full, f);
                mismatches++;
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                start;
    logic                busy;
    logic [KEY_W-1:0]    client_key;
    logic [TIME_W-1:0]   now_ms;
    logic                done;
    logic                allowed;
    logic [RETRY_W-1:0]  retry_after_s;
    logic                table_full;

    rate_ledger          ledger = new();
    int                  cycles = 0;
    int                  n_writes = 0;
    logic [TIME_W-1:0]   clock_ms;
    logic [TIME_W-1:0]   step;
    logic [KEY_W-1:0]    pool[$];
    logic [KEY_W-1:0]    key;
    int                  pool_n;
    int                  step_max;
    bit                  quiet;
    logic [CNT_W-1:0]    p_limit;
    logic [WIN_W-1:0]    p_window;

    per_client_fixed_window_rate_limiter u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .start         (start),
        .busy          (busy),
        .client_key    (client_key),
        .now_ms        (now_ms),
        .done          (done),
        .allowed       (allowed),
        .retry_after_s (retry_after_s),
        .table_full    (table_full)
    );

    always #1 clk = ~clk;

    // result beats are taken at every edge where done is high
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
            ledger.check_verdict(allowed, retry_after_s, table_full);
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("per_client_fixed_window_rate_limiter_tb: errors");
            $finish;
        end
    end

    // one request beat, held until the block takes it
    task automatic request(input logic [KEY_W-1:0] k, input logic [TIME_W-1:0] now);
        start      = 1'b1;
        client_key = k;
        now_ms     = now;
        do @(posedge clk); while (busy !== 1'b0);
        ledger.note_request(k, now);
        @(negedge clk);
    endtask

    task automatic rest(input int n);
        start = 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // hold off until every owed decision has come back
    task automatic drain();
        start = 1'b0;
        while (ledger.owed_verdicts.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic read_reg(input logic idx, input logic [DATA_W-1:0] want);
        logic [DATA_W-1:0] got;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        got = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (got !== want)
        begin
            $display("%0t: register %0d read expected %0d actual %0d", $time, idx, want, got);
            ledger.mismatches++;
        end
    endtask

    // setup and access cycle, then read back the stored value
    task automatic write_reg(input logic idx, input logic [DATA_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        n_writes++;
        if (idx == REG_MAX_REQUESTS)
        begin
            ledger.limit = value[CNT_W-1:0];
            read_reg(idx, DATA_W'(ledger.limit));
        end
        else
        begin
            ledger.window = value[WIN_W-1:0];
            read_reg(idx, DATA_W'(ledger.window));
        end
    endtask

    // both registers, with random junk above each field
    task automatic configure(input logic [CNT_W-1:0] lim, input logic [WIN_W-1:0] win);
        logic [DATA_W-1:0] word;
        drain();
        word = $urandom;
        word[CNT_W-1:0] = lim;
        write_reg(REG_MAX_REQUESTS, word);
        word = $urandom;
        word[WIN_W-1:0] = win;
        write_reg(REG_WINDOW_MS, word);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        start      = 1'b0;
        client_key = '0;
        now_ms     = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // clearing pass after reset
        while (busy !== 1'b0)
            @(negedge clk);
        read_reg(REG_MAX_REQUESTS, DATA_W'(DEF_MAX_REQUESTS));
        read_reg(REG_WINDOW_MS, DATA_W'(DEF_WINDOW_MS));

        // directed: reset settings, key extremes
        request('0, '0);
        request('1, '0);
        // limit of one: denial, retry floor of one second, expiry on the window end
        configure(16'd1, 27'd1000);
        request('0, 48'd10);
        request(64'd5, 48'd20);
        request(64'd5, 48'd500);
        request(64'd5, 48'd1020);
        // zero limit denies every tracked request
        configure(16'd0, 27'd1000);
        request(64'd7, 48'd2000);
        // zero window: each entry has expired by the next request
        configure(16'hFFFF, 27'd0);
        request(64'd8, 48'd3000);
        request(64'd8, 48'd3000);
        // widest window: retry saturates
        configure(16'd1, WINDOW_TOP);
        request(64'd9, 48'd4000);
        request(64'd9, 48'd4001);
        // time going backwards
        configure(16'd1, 27'd60000);
        request(64'd12, 48'd5000);
        request(64'd12, 48'd100);
        // window end saturates at the top of the time range
        request(64'd13, TIME_MAX - 48'd1000);
        request(64'd13, TIME_MAX);
        request(64'd13, TIME_MAX);
        request(64'd14, TIME_MAX);
        request(64'd14, TIME_MAX);

        // random phases, each with its own settings and client population
        clock_ms = '0;
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    p_limit = 16'd1;  p_window = 27'd1;  pool_n = 8;  step_max = 3;
                end
                1:
                begin
                    p_limit  = 16'($urandom_range(1, 2));
                    p_window = WINDOW_TOP;
                    pool_n   = 80;
                    step_max = 50;
                end
                2:
                begin
                    p_limit  = 16'd0;
                    p_window = 27'($urandom_range(1000, 30000));
                    pool_n   = 10;
                    step_max = 500;
                end
                3:
                begin
                    p_limit = 16'hFFFF;  p_window = 27'd0;  pool_n = 20;  step_max = 10;
                end
                default:
                begin
                    p_limit  = 16'($urandom_range(1, 6));
                    p_window = 27'($urandom_range(100, 20000));
                    pool_n   = $urandom_range(3, 90);
                    step_max = $urandom_range(1, 1500);
                end
            endcase
            // the long stretch without sender gaps
            quiet = (p == 3);
            configure(p_limit, p_window);
            clock_ms = clock_ms + TIME_W'({$urandom_range(0, 4095), $urandom});
            pool.delete();
            repeat (pool_n) pool.push_back({$urandom, $urandom});

            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                if ($urandom_range(0, 99) < 6)
                    key = {$urandom, $urandom};
                else
                    key = pool[$urandom_range(0, pool_n - 1)];
                step = TIME_W'($urandom_range(0, step_max));
                if ($urandom_range(0, 99) < 2 && clock_ms > step)
                    clock_ms = clock_ms - step;
                else
                    clock_ms = clock_ms + step;
                request(key, clock_ms);
                if (p == 5 && n == PHASE_BEATS / 2)
                    drain();
                else if (!quiet && $urandom_range(0, 99) < 24)
                    rest(($urandom_range(0, 3) == 0) ? $urandom_range(7, 130)
                                                     : $urandom_range(1, 6));
            end
        end

        drain();
        repeat (TAIL) @(negedge clk);

        $display("requests checked: %0d allowed, %0d denied, %0d passed untracked",
                 ledger.n_allowed, ledger.n_denied, ledger.n_untracked);
        $display("%0d register writes over %0d random phases, saturation and zero settings",
                 n_writes, PHASES);
        if (ledger.mismatches == 0)
            $display("per_client_fixed_window_rate_limiter_tb: clean");
        else
            $display("per_client_fixed_window_rate_limiter_tb: errors");
        $finish;
    end

endmodule

// File: per_client_fixed_window_rate_limiter.f
design/fwrl_pkg.sv
design/per_client_fixed_window_rate_limiter.sv
verif/per_client_fixed_window_rate_limiter_tb.sv
